// ===== hw/rtl/wtg_pkg.sv =====
// Shared types and constants of the two-channel wavetable generator.
`timescale 1ns / 1ps

package wtg_pkg;

	localparam int unsigned STEP_SIZE  = 32;
	localparam int unsigned PROM_DEPTH = 512;
	localparam int unsigned PROM_WIDTH = 4;
	localparam int unsigned PHASE_W    = 17;
	localparam int unsigned FREQ_W     = 12;
	localparam int unsigned DIV_W      = PHASE_W + FREQ_W - 1;
	localparam int unsigned ACC_W      = 9;
	localparam int unsigned SHIFT_W    = 5;
	// A trigger can leave a large counter under a small frequency, so the
	// divide runs over all 17 quotient bits.
	localparam logic [SHIFT_W-1:0] DIV_FIRST_SHIFT = 5'd16;
	// Once the steps down to bit five are done the remainder is the counter
	// modulo 32 times the frequency; the steps below give the wave index.
	localparam logic [SHIFT_W-1:0] DIV_WRAP_SHIFT  = 5'd5;
	localparam logic [FREQ_W-1:0]  FREQ_MAX        = 12'hfff;
	localparam logic [4:0]         SAMPLE_MID      = 5'd8;

	typedef enum logic [2:0] {
		MODE_TICK    = 3'd0,
		MODE_CONTROL = 3'd1,
		MODE_LATCH   = 3'd2,
		MODE_TRIGGER = 3'd3,
		MODE_PROM    = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_READ,
		S_ACC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic               accept;
		logic               clr_acc;
		logic               load;
		logic               div_step;
		logic               div_wrap;
		logic               div_index;
		logic [SHIFT_W-1:0] shift;
		logic               rd;
		logic               acc;
		logic               out_load;
		logic               voice;
	} cmd_t;

	typedef struct packed {
		logic active;
	} status_t;

endpackage

// ===== hw/rtl/wtg_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module wtg_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ===== hw/rtl/wtg_ctrl.sv =====
// Controller state machine: sequences the voices of one tick.
`timescale 1ns / 1ps

module wtg_ctrl import wtg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  mode_t   in_mode,
	output logic    in_ready,
	input  logic    out_ready,
	output logic    out_valid,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic voice_q, voice_d;
	logic [SHIFT_W-1:0] shift_q, shift_d;
	logic out_full_q;
	logic out_free;

	assign out_free  = !out_full_q || out_ready;
	assign out_valid = out_full_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_mode == MODE_TICK) state_d = S_LOAD;
			end
			S_LOAD: begin
				if (status.active) state_d = S_DIV;
				else if (voice_q) state_d = S_DONE;
			end
			S_DIV: begin
				if (shift_q == '0) state_d = S_READ;
			end
			S_READ: state_d = S_ACC;
			S_ACC: begin
				state_d = voice_q ? S_DONE : S_LOAD;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		voice_d   = voice_q;
		shift_d   = shift_q;
		cmd.voice = voice_q;
		cmd.shift = shift_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.accept  = in_valid;
				cmd.clr_acc = in_valid && in_mode == MODE_TICK;
				voice_d     = 1'b0;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				shift_d  = DIV_FIRST_SHIFT;
				// A silent voice skips its divide and leaves its phase alone.
				if (!status.active && !voice_q) voice_d = 1'b1;
			end
			S_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_wrap  = shift_q == DIV_WRAP_SHIFT;
				cmd.div_index = shift_q < DIV_WRAP_SHIFT;
				if (shift_q != '0) shift_d = shift_q - 1'b1;
			end
			S_READ: cmd.rd = 1'b1;
			S_ACC: begin
				cmd.acc = 1'b1;
				voice_d = 1'b1;
			end
			S_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			voice_q    <= 1'b0;
			shift_q    <= '0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			voice_q <= voice_d;
			shift_q <= shift_d;
			if (cmd.out_load) out_full_q <= 1'b1;
			else if (out_ready) out_full_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/wtg_dp.sv =====
// Datapath: voice registers, serial divider, wave PROM and mixer.
`timescale 1ns / 1ps

module wtg_dp import wtg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  mode_t       mode,
	input  logic        channel,
	input  logic [11:0] value,
	input  logic [8:0]  prom_address,
	input  logic [3:0]  prom_data,
	output logic [15:0] sample
);

	logic [PHASE_W-1:0] phase_q [2];
	logic [FREQ_W-1:0]  freq_act_q [2];
	logic [FREQ_W-1:0]  freq_pend_q [2];
	logic [2:0]         bank_q [2];
	logic [3:0]         level_q [2];

	logic [PHASE_W-1:0] rem_q;
	logic [4:0]         quo_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [15:0]        sample_q;

	logic [DIV_W-1:0]   divisor;
	logic [PHASE_W-1:0] rem_next;
	logic               ge;
	logic               prom_we;
	logic               prom_en;
	logic [8:0]         prom_addr;
	logic [3:0]         prom_rdata;
	logic signed [ACC_W-1:0] centered;
	logic signed [ACC_W-1:0] product;

	assign status.active = level_q[cmd.voice] != '0 && freq_act_q[cmd.voice] != '0;

	// One restoring step: compare against the frequency shifted to the current bit.
	assign divisor  = DIV_W'(freq_act_q[cmd.voice]) << cmd.shift;
	assign ge       = DIV_W'(rem_q) >= divisor;
	assign rem_next = ge ? rem_q - PHASE_W'(divisor) : rem_q;

	assign prom_we   = cmd.accept && mode == MODE_PROM;
	assign prom_en   = prom_we || cmd.rd;
	assign prom_addr = prom_we ? prom_address : {cmd.voice, bank_q[cmd.voice], quo_q};

	wtg_ram #(
		.WIDTH(PROM_WIDTH),
		.DEPTH(PROM_DEPTH)
	) u_prom (
		.clk  (clk),
		.en   (prom_en),
		.we   (prom_we),
		.addr (prom_addr),
		.wdata(prom_data),
		.rdata(prom_rdata)
	);

	assign centered = $signed(ACC_W'({1'b0, prom_rdata})) - $signed(ACC_W'(SAMPLE_MID));
	assign product  = ACC_W'(centered * $signed(ACC_W'(level_q[cmd.voice])));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				phase_q[i]     <= '0;
				freq_act_q[i]  <= '0;
				freq_pend_q[i] <= '0;
				bank_q[i]      <= '0;
				level_q[i]     <= '0;
			end
		end else begin
			if (cmd.accept) begin
				case (mode)
					MODE_CONTROL: begin
						level_q[channel] <= value[3:0];
						bank_q[channel]  <= value[7:5];
					end
					MODE_LATCH:   freq_pend_q[channel] <= FREQ_MAX - value;
					MODE_TRIGGER: freq_act_q[channel]  <= freq_pend_q[channel];
					default: ;
				endcase
			end
			// The step at bit five leaves the counter reduced modulo 32 times the frequency.
			if (cmd.div_step && cmd.div_wrap) phase_q[cmd.voice] <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) rem_q <= phase_q[cmd.voice] + PHASE_W'(STEP_SIZE);
		else if (cmd.div_step) rem_q <= rem_next;
		if (cmd.div_step && cmd.div_index) quo_q <= {quo_q[3:0], ge};
		if (cmd.clr_acc) acc_q <= '0;
		else if (cmd.acc) acc_q <= acc_q + product;
		if (cmd.out_load) sample_q <= {acc_q, 7'b0};
	end

	assign sample = sample_q;

endmodule

// ===== hw/rtl/two_channel_wavetable_generator.sv =====
// Top level of the two-channel wavetable generator.
//
//  channel  | fields (low bit up)                              | result
//  s_axis   | tuser: mode[2:0] channel[3]                      | request in
//           | tdata: value[11:0] prom_address[20:12]           |
//           |        prom_data[24:21], zero fill to 32         |
//  m_axis   | tdata: sample[15:0] signed                       | one per tick
//
// Control, latch, trigger and PROM requests are handled while idle and leave the
// generator ready for the next request. A tick loads each voice in turn; every sounding
// voice runs a 17-step restoring divide, a PROM read and an accumulate, and a silent one is skipped.
// The finished sample sits in an output register; the next request is taken
// while it waits, and a tick stalls only when the register is still full.
// Reset clears the voice registers; the PROM keeps its contents.
`timescale 1ns / 1ps

module two_channel_wavetable_generator import wtg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // value, prom_address, prom_data
	input  logic [3:0]  s_axis_tuser,  // mode, channel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // sample
);

	cmd_t    cmd;
	status_t status;
	mode_t   mode;

	assign mode = mode_t'(s_axis_tuser[2:0]);

	wtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (mode),
		.in_ready (s_axis_tready),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	wtg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.mode        (mode),
		.channel     (s_axis_tuser[3]),
		.value       (s_axis_tdata[11:0]),
		.prom_address(s_axis_tdata[20:12]),
		.prom_data   (s_axis_tdata[24:21]),
		.sample      (m_axis_tdata)
	);

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.load, cmd.div_step, cmd.rd, cmd.acc, cmd.out_load}))
		else $error("datapath got more than one command");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && mode == MODE_TICK) |=> !s_axis_tready)
		else $error("request taken while a tick is in progress");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_axis_tvalid)
		else $error("sample loaded but not presented");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !s_axis_tready && !cmd.accept)
		else $error("divider step while taking requests");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the two-channel wavetable generator.
`timescale 1ns / 1ps

module tb;
	import wtg_pkg::*;

	localparam int          CYCLE_LIMIT     = 1_000_000;
	localparam int          RANDOM_ITEMS    = 750;
	localparam int          PRESSURE_CYCLES = 400;
	localparam int          DRAIN_CYCLES    = 60;
	localparam int unsigned WAVE_LEN        = 32;
	localparam logic [2:0]  MODE_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  MODE_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [2:0]  mode;
		logic        channel;
		logic [11:0] value;
		logic [8:0]  prom_address;
		logic [3:0]  prom_data;
	} req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	// Voice state as the generator should hold it.
	logic [PHASE_W-1:0]    phase[2];
	logic [FREQ_W-1:0]     freq_active[2];
	logic [FREQ_W-1:0]     freq_pending[2];
	logic [2:0]            bank[2];
	logic [3:0]            level[2];
	logic [PROM_WIDTH-1:0] prom[PROM_DEPTH];
	bit                    prom_written[PROM_DEPTH];

	req_t        pending_requests[$];
	logic [15:0] samples_due[$];
	int          counted_items = 0;
	int          requests_sent = 0;
	int          failures = 0;
	int          cycle_count = 0;
	int          send_gap = 0;
	int          send_calm = 0;
	int          ready_wait = 0;
	int          ready_calm = 0;
	int          pressure_at[$] = '{150, 500};
	req_t        next_req;
	logic [15:0] due;

	two_channel_wavetable_generator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic bit voice_sounding(bit ch);
		return level[ch] != 0 && freq_active[ch] != 0;
	endfunction

	// PROM entry the voice will read on its next tick; only valid while it sounds.
	function automatic logic [8:0] voice_read_addr(bit ch);
		int unsigned advanced;
		logic [4:0]  idx;
		advanced = int'(phase[ch]) + STEP_SIZE;
		idx = 5'(advanced / freq_active[ch]);
		return {ch, bank[ch], idx};
	endfunction

	function automatic int voice_output(bit ch);
		logic [8:0] addr;
		if (!voice_sounding(ch))
			return 0;
		addr = voice_read_addr(ch);
		phase[ch] = PHASE_W'((int'(phase[ch]) + STEP_SIZE) % (freq_active[ch] * WAVE_LEN));
		return (int'(prom[addr]) - 8) * int'(level[ch]);
	endfunction

	function automatic void advance_model(req_t r);
		int mix;
		case (r.mode)
			MODE_TICK: begin
				mix = voice_output(1'b0) + voice_output(1'b1);
				samples_due.push_back(16'(mix * 128));
			end
			MODE_CONTROL: begin
				level[r.channel] = r.value[3:0];
				bank[r.channel] = r.value[7:5];
			end
			MODE_LATCH: freq_pending[r.channel] = FREQ_MAX - r.value;
			MODE_TRIGGER: freq_active[r.channel] = freq_pending[r.channel];
			MODE_PROM: begin
				prom[r.prom_address] = r.prom_data;
				prom_written[r.prom_address] = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// Every field is random, so bits the mode does not use still toggle.
	function automatic req_t fresh_request(logic [2:0] mode);
		req_t r;
		r = req_t'($urandom);
		r.mode = mode;
		return r;
	endfunction

	function automatic void post_request(req_t r);
		advance_model(r);
		pending_requests.push_back(r);
		if (r.mode <= MODE_PROM)
			counted_items++;
	endfunction

	// A sounding voice must never read an entry that was never loaded, so the
	// entry it is about to read is loaded first when needed.
	function automatic void post_tick();
		logic [8:0] addr;
		req_t       r;
		for (int ch = 0; ch < 2; ch++) begin
			if (voice_sounding(1'(ch))) begin
				addr = voice_read_addr(1'(ch));
				if (!prom_written[addr]) begin
					r = fresh_request(MODE_PROM);
					r.prom_address = addr;
					post_request(r);
				end
			end
		end
		post_request(fresh_request(MODE_TICK));
	endfunction

	function automatic int pick_gap(inout int calm_left);
		int roll;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			calm_left = $urandom_range(30, 120);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				requests_sent <= requests_sent + 1;
			if (send_gap != 0 || pending_requests.size() == 0) begin
				if (send_gap != 0)
					send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else begin
				next_req = pending_requests.pop_front();
				s_tdata <= {7'd0, next_req.prom_data, next_req.prom_address, next_req.value};
				s_tuser <= {next_req.channel, next_req.mode};
				s_tvalid <= 1'b1;
				send_gap <= pick_gap(send_calm);
			end
		end
	end

	// The receiver stalls after results at random and now and then for a long
	// stretch, so the output register fills and ticks back up into the input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				ready_wait = pick_gap(ready_calm);
			if (pressure_at.size() != 0 && requests_sent >= pressure_at[0]) begin
				void'(pressure_at.pop_front());
				ready_wait = PRESSURE_CYCLES;
			end
			if (ready_wait != 0) begin
				ready_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (samples_due.size() == 0) begin
				$error("sample: no result expected, actual %0d", $signed(m_tdata));
				failures++;
			end else begin
				due = samples_due.pop_front();
				if (m_tdata !== due) begin
					$error("sample: expected %0d, actual %0d", $signed(due), $signed(m_tdata));
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** two_channel_wavetable_generator: FAILED **");
			$finish;
		end
	end

	initial begin
		req_t r;
		int   roll;
		int   ch;
		int   target;

		for (int i = 0; i < 2; i++) begin
			phase[i] = '0;
			freq_active[i] = '0;
			freq_pending[i] = '0;
			bank[i] = '0;
			level[i] = '0;
		end

		// Full scale on both voices: frequency 1 keeps both on wave index 0.
		r = fresh_request(MODE_PROM); r.prom_address = 9'd224; r.prom_data = 4'hf; post_request(r);
		r = fresh_request(MODE_PROM); r.prom_address = 9'd480; r.prom_data = 4'hf; post_request(r);
		// Control bit 4 and the top nibble of the value must be ignored.
		r = fresh_request(MODE_CONTROL); r.channel = 1'b0; r.value = 12'hfff; post_request(r);
		r = fresh_request(MODE_CONTROL); r.channel = 1'b1; r.value = 12'h0ef; post_request(r);
		post_tick();
		r = fresh_request(MODE_LATCH); r.channel = 1'b0; r.value = 12'hffe; post_request(r);
		r = fresh_request(MODE_LATCH); r.channel = 1'b1; r.value = 12'hffe; post_request(r);
		post_tick();
		r = fresh_request(MODE_TRIGGER); r.channel = 1'b0; post_request(r);
		r = fresh_request(MODE_TRIGGER); r.channel = 1'b1; post_request(r);
		post_tick();
		r = fresh_request(MODE_PROM); r.prom_address = 9'd224; r.prom_data = 4'h0; post_request(r);
		r = fresh_request(MODE_PROM); r.prom_address = 9'd480; r.prom_data = 4'h0; post_request(r);
		post_tick();
		for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
			post_request(fresh_request(3'(m)));
		// Slowest frequency on voice 0, zero frequency on voice 1.
		r = fresh_request(MODE_LATCH); r.channel = 1'b0; r.value = 12'h000; post_request(r);
		r = fresh_request(MODE_TRIGGER); r.channel = 1'b0; post_request(r);
		r = fresh_request(MODE_LATCH); r.channel = 1'b1; r.value = 12'hfff; post_request(r);
		r = fresh_request(MODE_TRIGGER); r.channel = 1'b1; post_request(r);
		post_tick();
		r = fresh_request(MODE_CONTROL); r.channel = 1'b0; r.value = 12'h010; post_request(r);
		post_tick();
		r = fresh_request(MODE_PROM); r.prom_address = 9'd0; post_request(r);
		r = fresh_request(MODE_PROM); r.prom_address = 9'd511; post_request(r);

		target = counted_items + RANDOM_ITEMS;
		while (counted_items < target) begin
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				// Program one voice, then let it play for a while.
				ch = $urandom_range(0, 1);
				if ($urandom_range(0, 99) < 80) begin
					r = fresh_request(MODE_CONTROL);
					r.channel = 1'(ch);
					if ($urandom_range(0, 99) < 15)
						r.value[3:0] = '0;
					post_request(r);
				end
				if ($urandom_range(0, 99) < 80) begin
					r = fresh_request(MODE_LATCH);
					r.channel = 1'(ch);
					roll = $urandom_range(0, 99);
					if (roll < 45)
						r.value = FREQ_MAX - 12'($urandom_range(1, 64));
					else if (roll < 55)
						r.value = FREQ_MAX;
					else if (roll < 60)
						r.value = '0;
					post_request(r);
				end
				if ($urandom_range(0, 99) < 85) begin
					r = fresh_request(MODE_TRIGGER);
					r.channel = 1'(ch);
					post_request(r);
				end
				repeat ($urandom_range(0, 4)) begin
					r = fresh_request(MODE_PROM);
					r.prom_address = {1'(ch), bank[ch], 5'($urandom)};
					post_request(r);
				end
				repeat ($urandom_range(4, 24))
					post_tick();
			end else if (roll < 70) begin
				repeat ($urandom_range(1, 10))
					post_tick();
			end else if (roll < 85) begin
				r = fresh_request(3'($urandom_range(MODE_TICK, MODE_PROM)));
				if (r.mode == MODE_TICK)
					post_tick();
				else
					post_request(r);
			end else if (roll < 90) begin
				post_request(fresh_request(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST))));
			end else begin
				// Load a run of neighbouring PROM entries in a row.
				r = fresh_request(MODE_PROM);
				repeat ($urandom_range(8, 32)) begin
					r.prom_data = 4'($urandom);
					post_request(r);
					r.prom_address = r.prom_address + 9'd1;
				end
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || s_tvalid)
			@(posedge clk);
		while (samples_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && samples_due.size() == 0)
			$display("** two_channel_wavetable_generator: PASSED **");
		else
			$display("** two_channel_wavetable_generator: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/wtg_pkg.sv
hw/rtl/wtg_ram.sv
hw/rtl/wtg_ctrl.sv
hw/rtl/wtg_dp.sv
hw/rtl/two_channel_wavetable_generator.sv
tb/tb.sv
